// ===== hdl/clpt_pkg.sv =====
package clpt_pkg;

	localparam int ENTRIES  = 64;
	localparam int ID_BITS  = 16;
	localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FUNC_W   = 3;
	localparam int OBJ_W    = 16;

	localparam logic [FUNC_W-1:0] FN_BEGIN    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REGISTER = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MARK     = 3'd2;
	localparam logic [FUNC_W-1:0] FN_PURGE    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_QUERY    = 3'd4;

	typedef enum logic [1:0] {
		PH_NONE,
		PH_ENTER,
		PH_STAY,
		PH_EXIT
	} ph_t;

	typedef struct packed {
		logic                 used;
		logic                 live;
		ph_t                  phase;
		logic [ID_BITS-1:0]   first;
		logic [ID_BITS-1:0]   second;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ID_BITS-1:0] a;
		logic [ID_BITS-1:0] b;
		logic               hit;
	} cmd_t;

	typedef struct packed {
		logic found;
		ph_t  phase;
		logic accepted;
		logic full;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_WRITE,
		ST_DONE
	} st_t;

endpackage

// ===== hdl/clpt_ram.sv =====
module clpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/clpt_engine.sv =====
module clpt_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  clpt_pkg::cmd_t                      cmd,
	output logic                                idle,
	output logic                                res_valid,
	output clpt_pkg::res_t                      res,
	input  logic                                res_take,
	output logic                                mem_we,
	output logic [clpt_pkg::IDX_BITS-1:0]       mem_waddr,
	output clpt_pkg::slot_t                     mem_wdata,
	output logic [clpt_pkg::IDX_BITS-1:0]       mem_raddr,
	input  clpt_pkg::slot_t                     mem_rdata
);

	import clpt_pkg::*;

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

	st_t                 state_q, state_d;
	logic [IDX_BITS-1:0] cnt_q;
	logic                cnt_last;
	cmd_t                cmd_q;
	logic                rd_vld_s1;
	logic [IDX_BITS-1:0] addr_s1;
	logic                match_q, free_q;
	logic [IDX_BITS-1:0] match_idx_q, free_idx_q;
	ph_t                 match_ph_q;
	res_t                res_q;

	slot_t               mod_slot, new_slot;
	logic                hit_pair, scan_op, scan_wr, wr_reg;
	logic [IDX_BITS-1:0] wr_idx;
	res_t                res_d;

	assign cnt_last = (cnt_q == LAST_IDX);
	assign scan_op  = (cmd_q.func == FN_BEGIN) || (cmd_q.func == FN_MARK) ||
		(cmd_q.func == FN_PURGE);
	assign scan_wr  = rd_vld_s1 && scan_op;
	assign hit_pair = mem_rdata.used &&
		((mem_rdata.first == cmd_q.a && mem_rdata.second == cmd_q.b) ||
		 (mem_rdata.first == cmd_q.b && mem_rdata.second == cmd_q.a));

	// per-entry update for the sweeping operations
	always_comb begin
		mod_slot = mem_rdata;
		case (cmd_q.func)
			FN_BEGIN: begin
				mod_slot.live = 1'b0;
			end
			FN_MARK: begin
				if (mem_rdata.used && !mem_rdata.live && mem_rdata.phase != PH_EXIT) begin
					mod_slot.live  = 1'b1;
					mod_slot.phase = PH_EXIT;
				end
			end
			FN_PURGE: begin
				if (mem_rdata.used && !mem_rdata.live) begin
					mod_slot.used  = 1'b0;
					mod_slot.phase = PH_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	// final decision once the whole table has been seen
	always_comb begin
		res_d          = '0;
		new_slot.used  = 1'b1;
		new_slot.live  = 1'b1;
		new_slot.phase = PH_ENTER;
		new_slot.first = cmd_q.a;
		new_slot.second = cmd_q.b;
		wr_reg         = 1'b0;
		wr_idx         = free_idx_q;
		if (cmd_q.func == FN_REGISTER) begin
			if (match_q) begin
				res_d.found = 1'b1;
				if (cmd_q.hit) begin
					wr_reg         = 1'b1;
					wr_idx         = match_idx_q;
					new_slot.phase = PH_STAY;
					res_d.phase    = PH_STAY;
					res_d.accepted = 1'b1;
				end else begin
					res_d.phase = match_ph_q;
				end
			end else if (cmd_q.hit) begin
				if (free_q) begin
					wr_reg         = 1'b1;
					res_d.phase    = PH_ENTER;
					res_d.accepted = 1'b1;
				end else begin
					res_d.full = 1'b1;
				end
			end
		end else if (cmd_q.func == FN_QUERY && match_q) begin
			res_d.found = 1'b1;
			res_d.phase = match_ph_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_last) state_d = ST_TAIL;
			end
			ST_TAIL: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_we    = scan_wr;
		mem_waddr = addr_s1;
		mem_wdata = mod_slot;
		mem_raddr = cnt_q;
		idle      = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = slot_t'('0);
			end
			ST_IDLE: begin
				idle = 1'b1;
			end
			ST_WRITE: begin
				mem_we    = wr_reg;
				mem_waddr = wr_idx;
				mem_wdata = new_slot;
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (start && state_q == ST_IDLE) begin
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (rd_vld_s1) begin
				// keep the lowest hit and the lowest free entry
				if (hit_pair && !match_q) match_q <= 1'b1;
				if (!mem_rdata.used && !free_q) free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		if (start && state_q == ST_IDLE) begin
			cmd_q <= cmd;
		end
		if (rd_vld_s1 && hit_pair && !match_q) begin
			match_idx_q <= addr_s1;
			match_ph_q  <= mem_rdata.phase;
		end
		if (rd_vld_s1 && !mem_rdata.used && !free_q) begin
			free_idx_q <= addr_s1;
		end
		if (state_q == ST_WRITE) begin
			res_q <= res_d;
		end
	end

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_q.accepted && res_q.full))
		else $error("accepted and table_full both set");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_q.full) |-> (!res_q.found && res_q.phase == PH_NONE))
		else $error("dropped pair reports a phase");

	a_acc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_q.accepted) |->
		(res_q.phase == PH_ENTER || res_q.phase == PH_STAY))
		else $error("accepted pair has wrong phase");

	a_ins_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && mem_we) |-> (cmd_q.func == FN_REGISTER && cmd_q.hit))
		else $error("table written without a hit");

	a_rd_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == ST_SCAN))
		else $error("read data outside a sweep");

endmodule

// ===== hdl/contact_pair_lifecycle_table.sv =====
// Contact pair table: up to ENTRIES unordered object pairs, each with a live
// mark and an enter/stay/exit phase. Every transaction on the input channel
// (begin frame, register, mark exiting, purge, query) yields exactly one
// transaction on the output channel. Each operation sweeps the whole table in
// a single-port-read, single-port-write RAM, one entry per cycle. A new input
// is taken once the previous result is parked in the output register. After
// reset the RAM is cleared entry by entry, during which in_stall stays high.
module contact_pair_lifecycle_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [clpt_pkg::FUNC_W-1:0]  func,
	input  logic [clpt_pkg::OBJ_W-1:0]   first_object,
	input  logic [clpt_pkg::OBJ_W-1:0]   second_object,
	input  logic                         hit,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [1:0]                   pair_phase,
	output logic                         accepted,
	output logic                         table_full
);

	import clpt_pkg::*;

	cmd_t                cmd;
	res_t                eng_res;
	res_t                res_out_q;
	logic                eng_idle, eng_res_valid, res_take, start;
	logic                out_valid_q;
	logic                mem_we;
	logic [IDX_BITS-1:0] mem_waddr, mem_raddr;
	slot_t               mem_wdata, mem_rdata;
	logic [SLOT_W-1:0]   ram_rdata;

	assign cmd.func = func;
	assign cmd.a    = ID_BITS'(first_object);
	assign cmd.b    = ID_BITS'(second_object);
	assign cmd.hit  = hit;

	assign in_stall = !eng_idle;
	assign start    = in_valid && eng_idle;
	assign res_take = eng_res_valid && (!out_valid_q || !out_stall);

	clpt_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(SLOT_W'(mem_wdata)),
		.raddr(mem_raddr),
		.rdata(ram_rdata)
	);

	assign mem_rdata = slot_t'(ram_rdata);

	clpt_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.idle     (eng_idle),
		.res_valid(eng_res_valid),
		.res      (eng_res),
		.res_take (res_take),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// hold the result until the downstream side takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			res_out_q <= eng_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = res_out_q.found;
	assign pair_phase = res_out_q.phase;
	assign accepted   = res_out_q.accepted;
	assign table_full = res_out_q.full;

endmodule
